FILE: hw/rtl/pfb_pkg.sv
// Shared types and constants for the page frame buffer refresh block.
package pfb_pkg;

    localparam int unsigned PAGE_BITS = 4;
    localparam int unsigned CMD_STEPS = 3;

    localparam logic [1:0] OP_DRAW    = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       pixel_on;
    } pfb_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
    } pfb_out_t;

    typedef enum logic [1:0] {
        KIND_DRAW,
        KIND_CLEAR,
        KIND_REFRESH
    } pfb_kind_t;

    typedef struct packed {
        pfb_kind_t             kind;
        logic [7:0]            col;
        logic [PAGE_BITS-1:0]  page;
        logic [7:0]            mask;
        logic                  set;
    } pfb_cmd_t;

    typedef struct packed {
        logic     valid;
        pfb_cmd_t cmd;
    } pfb_head_t;

    typedef struct packed {
        logic idle;
        logic wiping;
    } pfb_back_stat_t;

endpackage

FILE: hw/rtl/pfb_front.sv
// Front end: classifies transactions and queues work for the back engine.
module pfb_front #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  pfb_pkg::pfb_in_t        item,
    input  pfb_pkg::pfb_back_stat_t back_stat,
    output logic                    full,
    output pfb_pkg::pfb_head_t      head
);
    import pfb_pkg::*;

    localparam int QD  = 2;
    localparam int QPW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    pfb_cmd_t         q_reg [QD];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;

    pfb_cmd_t         cmd;
    logic             keep;
    logic             x_ok;
    logic             y_ok;
    logic             accept;
    logic             push;
    logic             pop;

    // classify: out-of-range draws and the unused opcode are dropped here
    always_comb
    begin
        x_ok     = {1'b0, item.pixel_x} < 9'(COLUMNS);
        y_ok     = {1'b0, item.pixel_y} < 9'(PAGES * 8);
        cmd.col  = item.pixel_x;
        cmd.page = PAGE_BITS'(PAGES - 1 - int'(item.pixel_y[7:3]));
        cmd.mask = 8'h80 >> item.pixel_y[2:0];
        cmd.set  = item.pixel_on;
        cmd.kind = KIND_DRAW;
        keep     = 1'b0;
        unique case (item.opcode)
            OP_DRAW:
            begin
                cmd.kind = KIND_DRAW;
                keep     = x_ok && y_ok;
            end
            OP_CLEAR:
            begin
                cmd.kind = KIND_CLEAR;
                keep     = 1'b1;
            end
            OP_REFRESH:
            begin
                cmd.kind = KIND_REFRESH;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full       = (count_reg == QCW'(QD));
    assign accept     = start && !full && !back_stat.wiping;
    assign push       = accept && keep;
    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];
    assign pop        = head.valid && back_stat.idle;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

FILE: hw/rtl/pfb_back.sv
// Back engine: pixel store, clearing pass, draw read-modify-write, refresh stream.
module pfb_back #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pfb_pkg::pfb_head_t      head,
    output pfb_pkg::pfb_back_stat_t stat,
    output logic                    done,
    output pfb_pkg::pfb_out_t       result
);
    import pfb_pkg::*;

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int SW    = $clog2(COLUMNS + CMD_STEPS);

    typedef enum logic [1:0] {
        ST_WIPE,
        ST_IDLE,
        ST_DRAW_WR,
        ST_REF_RD
    } state_t;

    logic [7:0]     mem [DEPTH];
    logic [7:0]     rdata_reg;

    state_t         state_reg, state_next;
    logic [AW-1:0]  wipe_reg, wipe_next;
    logic [AW-1:0]  draw_addr_reg, draw_addr_next;
    logic [7:0]     mask_reg, mask_next;
    logic           set_reg, set_next;
    logic [PW-1:0]  page_reg, page_next;
    logic [SW-1:0]  pos_reg, pos_next;
    logic           done_reg, done_next;
    pfb_out_t       result_reg, result_next;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;

    logic [AW-1:0]  head_addr;
    logic [AW-1:0]  ref_addr;
    logic [CW-1:0]  ref_col;
    logic           last_col;
    logic           last_page;
    logic           in_cmd;

    assign head_addr = AW'(int'(head.cmd.page) * COLUMNS + int'(head.cmd.col));
    assign ref_col   = CW'(pos_reg - SW'(CMD_STEPS));
    assign ref_addr  = AW'(int'(page_reg) * COLUMNS + int'(ref_col));
    assign last_col  = (ref_col == CW'(COLUMNS - 1));
    assign last_page = (page_reg == PW'(PAGES - 1));
    assign in_cmd    = (pos_reg < SW'(CMD_STEPS));

    always_comb
    begin
        state_next     = state_reg;
        wipe_next      = wipe_reg;
        draw_addr_next = draw_addr_reg;
        mask_next      = mask_reg;
        set_next       = set_reg;
        page_next      = page_reg;
        pos_next       = pos_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_waddr      = wipe_reg;
        mem_wdata      = 8'h00;
        mem_re         = 1'b0;
        mem_raddr      = head_addr;

        unique case (state_reg)
            ST_WIPE:
            begin
                mem_we    = 1'b1;
                wipe_next = wipe_reg + 1'b1;
                if (wipe_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (head.cmd.kind)
                        KIND_DRAW:
                        begin
                            mem_re         = 1'b1;
                            draw_addr_next = head_addr;
                            mask_next      = head.cmd.mask;
                            set_next       = head.cmd.set;
                            state_next     = ST_DRAW_WR;
                        end
                        KIND_CLEAR:
                        begin
                            wipe_next  = '0;
                            page_next  = '0;
                            pos_next   = '0;
                            state_next = ST_WIPE;
                        end
                        KIND_REFRESH:
                        begin
                            if (in_cmd)
                            begin
                                done_next             = 1'b1;
                                result_next.is_data   = 1'b0;
                                result_next.frame_end = 1'b0;
                                if (pos_reg == '0)
                                begin
                                    result_next.out_byte = CMD_PAGE_BASE + 8'(page_reg);
                                end
                                else if (pos_reg == SW'(1))
                                begin
                                    result_next.out_byte = CMD_COL_LOW;
                                end
                                else
                                begin
                                    result_next.out_byte = CMD_COL_HIGH;
                                end
                                pos_next = pos_reg + 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = ref_addr;
                                state_next = ST_REF_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAW_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = draw_addr_reg;
                mem_wdata  = set_reg ? (rdata_reg | mask_reg) : (rdata_reg & ~mask_reg);
                state_next = ST_IDLE;
            end
            ST_REF_RD:
            begin
                done_next             = 1'b1;
                result_next.out_byte  = rdata_reg;
                result_next.is_data   = 1'b1;
                result_next.frame_end = last_col && last_page;
                if (last_col)
                begin
                    pos_next  = '0;
                    page_next = last_page ? '0 : page_reg + 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            wipe_reg      <= '0;
            draw_addr_reg <= '0;
            mask_reg      <= '0;
            set_reg       <= 1'b0;
            page_reg      <= '0;
            pos_reg       <= '0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wipe_reg      <= wipe_next;
            draw_addr_reg <= draw_addr_next;
            mask_reg      <= mask_next;
            set_reg       <= set_next;
            page_reg      <= page_next;
            pos_reg       <= pos_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign stat.idle   = (state_reg == ST_IDLE);
    assign stat.wiping = (state_reg == ST_WIPE);
    assign done        = done_reg;
    assign result      = result_reg;

endmodule

FILE: hw/rtl/page_frame_buffer_refresh.sv
// Top level of the monochrome page frame buffer with refresh byte stream.
//
// Holds a COLUMNS x PAGES byte frame (8 pixel rows per page, row y lands in
// page PAGES-1-y/8, bit 7-y%8) and produces the panel refresh stream one byte
// per refresh transaction: 0xB0+page, 0x00, 0x10, then COLUMNS data bytes per
// page, wrapping after the last page; frame_end marks the final data byte.
// A transaction is taken when start is high and busy is low. The front end
// decodes it and drops out-of-range draws and the unused opcode; real work
// goes into a two-entry queue, so start can be given every cycle until the
// queue fills or a clearing pass runs. The back engine works off one queued
// transaction at a time: a draw is a registered memory read, then a write; a
// refresh command byte is registered straight from the idle state; a refresh
// data byte is a memory read issued in idle and shown from ST_REF_RD; a clear
// is a decode step, then one store byte zeroed per cycle with busy held high.
// After reset the same clearing pass runs with busy held high.
// Each result is shown on result for exactly one cycle with done high; there
// is no back-pressure, so the receiver must take it in that cycle.
module page_frame_buffer_refresh #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pfb_pkg::pfb_in_t  item,
    output logic              done,
    output pfb_pkg::pfb_out_t result
);
    import pfb_pkg::*;

    pfb_head_t      head;
    pfb_back_stat_t back_stat;
    logic           q_full;

    // front: decode and queue
    pfb_front #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .back_stat (back_stat),
        .full      (q_full),
        .head      (head)
    );

    // back: store and refresh sequencer
    pfb_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .stat   (back_stat),
        .done   (done),
        .result (result)
    );

    // stall new transactions while the queue is full or a clearing pass runs
    assign busy = q_full || back_stat.wiping;

endmodule

FILE: hw/rtl/pfb_checker.sv
// Port-level assertions for the page frame buffer, bound to the top level.
module pfb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input pfb_pkg::pfb_in_t  item,
    input logic              done,
    input pfb_pkg::pfb_out_t result
);
    import pfb_pkg::*;

    // frame end only ever marks a data byte
    a_end_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.frame_end |-> result.is_data)
        else $error("frame_end on a command byte");

    // command bytes are page select or the two column resets
    a_cmd_values: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.is_data |->
            (result.out_byte == CMD_COL_LOW) || (result.out_byte == CMD_COL_HIGH)
            || (result.out_byte[7:4] == CMD_PAGE_BASE[7:4]))
        else $error("unexpected command byte");

    // post-reset clearing pass holds off new transactions
    a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> busy)
        else $error("busy low right after reset");

    // no result comes out right after reset, before any transaction was taken
    a_no_done_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !done)
        else $error("result right after reset");

    // an accepted transaction carries a known opcode
    a_item_known: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> !$isunknown(item.opcode))
        else $error("opcode unknown on accepted transaction");

endmodule

bind page_frame_buffer_refresh pfb_checker u_pfb_checker (.*);
